// ===== rtl/core/tbpr_pkg.sv =====
package tbpr_pkg;

  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_ADD   = 3'd1;
  localparam logic [2:0] FUNC_COEF  = 3'd2;
  localparam logic [2:0] FUNC_POINT = 3'd3;
  localparam logic [2:0] FUNC_TICK  = 3'd4;

  localparam logic CFG_PADDING = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam int NUM_COEF = 12;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [19:0] PADDING_RST = 20'd6554;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;

  // centre x/y/z (32 each), half extent x/y/z (31 each)
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0] hx;
    logic [30:0] hy;
    logic [30:0] hz;
  } box_t;

  function automatic logic [30:0] half_ext(input logic [30:0] size, input logic [19:0] pad);
    logic [31:0] h;
    h = {2'b0, size[30:1]} + {12'b0, pad};
    half_ext = h[31] ? 31'h7fff_ffff : h[30:0];
  endfunction

  // |q - c| <= h with q 36 bits signed
  function automatic logic in_range(input logic signed [35:0] q, input logic signed [31:0] c,
                                    input logic [30:0] h);
    logic signed [36:0] d;
    d = {q[35], q} - 37'(c);
    if (d[36]) d = -d;
    in_range = d <= 37'(h);
  endfunction

endpackage

// ===== rtl/core/tbpr_box_mem.sv =====
module tbpr_box_mem #(
  parameter int MAX_BOXES = 32,
  parameter int AW = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  tbpr_pkg::box_t    wdata,
  input  logic [AW-1:0]     raddr,
  output tbpr_pkg::box_t    rdata
);

  tbpr_pkg::box_t mem [MAX_BOXES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/transformed_box_point_rejector.sv =====
// channel | dir | transaction
// in_     | in  | command: func, point/box/coef data
// out_    | out | one result per point command
// cfg_    | in  | register write: 0 padding, 1 timeout_ticks
//
// non-point commands are taken in S_IDLE, which the state keeps; a point that bypasses
// the boxes loads its result in the cycle after acceptance and input reopens once the
// state is back in S_IDLE. a checked point runs the transform (multiply then sum, per
// row) in S_ROW and S_SUM, reads the stored boxes in turn in S_SCAN until a hit or the
// last box, and loads the result in S_DONE.
// synchronous active-low reset clears counts and age, sets the transform to identity and the registers to defaults.
// input is held off while a result waits unaccepted in the output register.
module transformed_box_point_rejector #(
  parameter int MAX_BOXES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // val_x, val_y, val_z, size_x, size_y, size_z, coef_index, frame_ok (200 bits)
  input  logic [199:0] in_tdata,
  input  logic         in_tlast,   // last_point
  input  logic [2:0]   in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  // keep, out_x, out_y, out_z
  output logic [103:0] out_tdata,
  output logic         out_tlast,  // cloud_end
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [19:0]  cfg_data
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [2:0] {S_IDLE, S_ROW, S_SUM, S_SCAN, S_DONE} state_t;

  state_t state_r;
  logic [CW-1:0] box_count_r;
  logic [15:0] set_age_r;
  logic set_seen_r;
  logic [19:0] padding_r;
  logic [15:0] timeout_r;
  logic signed [31:0] coef_r [tbpr_pkg::NUM_COEF];
  logic signed [31:0] px_r, py_r, pz_r;
  logic last_r;
  logic [1:0] row_r;
  logic signed [35:0] q_r [3];
  logic signed [63:0] prod_r [3];
  logic [CW-1:0] scan_r;
  logic hit_r;
  logic out_valid_r;
  logic [103:0] out_data_r;
  logic out_last_r;

  logic [2:0] func;
  logic signed [31:0] vx, vy, vz;
  logic [30:0] sx, sy, sz;
  logic [3:0] ci;
  logic fok;
  logic in_fire;

  assign func = in_tuser;
  assign vx = in_tdata[31:0];
  assign vy = in_tdata[63:32];
  assign vz = in_tdata[95:64];
  assign sx = in_tdata[126:96];
  assign sy = in_tdata[157:127];
  assign sz = in_tdata[188:158];
  assign ci = in_tdata[192:189];
  assign fok = in_tdata[193];

  assign in_tready = (state_r == S_IDLE) && !(out_valid_r && !out_tready);
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  logic active;
  assign active = set_seen_r && (set_age_r < timeout_r) && (box_count_r != '0) && fok;

  tbpr_pkg::box_t wbox, rbox;
  logic we;
  assign wbox.cx = vx;
  assign wbox.cy = vy;
  assign wbox.cz = vz;
  assign wbox.hx = tbpr_pkg::half_ext(sx, padding_r);
  assign wbox.hy = tbpr_pkg::half_ext(sy, padding_r);
  assign wbox.hz = tbpr_pkg::half_ext(sz, padding_r);
  assign we = in_fire && func == tbpr_pkg::FUNC_ADD && box_count_r < CW'(MAX_BOXES);

  tbpr_box_mem #(.MAX_BOXES(MAX_BOXES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(box_count_r[AW-1:0]), .wdata(wbox),
    .raddr(scan_r[AW-1:0]), .rdata(rbox)
  );

  // row products, registered
  logic [3:0] base;
  assign base = 4'(row_r) * 4'd3;

  logic signed [35:0] sum;
  always_comb begin
    sum = 36'(coef_r[4'd9 + 4'(row_r)]);
    sum = sum + 36'(prod_r[0] >>> 30);
    sum = sum + 36'(prod_r[1] >>> 30);
    sum = sum + 36'(prod_r[2] >>> 30);
  end

  logic hit_now;
  assign hit_now = tbpr_pkg::in_range(q_r[0], rbox.cx, rbox.hx) &&
                   tbpr_pkg::in_range(q_r[1], rbox.cy, rbox.hy) &&
                   tbpr_pkg::in_range(q_r[2], rbox.cz, rbox.hz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      box_count_r <= '0;
      set_age_r <= '0;
      set_seen_r <= 1'b0;
      padding_r <= tbpr_pkg::PADDING_RST;
      timeout_r <= tbpr_pkg::TIMEOUT_RST;
      for (int i = 0; i < tbpr_pkg::NUM_COEF; i++) begin
        coef_r[i] <= (i == 0 || i == 4 || i == 8) ? tbpr_pkg::Q30_ONE : '0;
      end
      out_valid_r <= 1'b0;
      row_r <= '0;
      scan_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == tbpr_pkg::CFG_PADDING) padding_r <= cfg_data;
        else timeout_r <= cfg_data[15:0];
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (func)
              tbpr_pkg::FUNC_CLEAR: begin
                box_count_r <= '0;
                set_age_r <= '0;
                set_seen_r <= 1'b1;
              end
              tbpr_pkg::FUNC_ADD: begin
                if (we) box_count_r <= box_count_r + 1'b1;
              end
              tbpr_pkg::FUNC_COEF: begin
                if (ci < 4'(tbpr_pkg::NUM_COEF)) coef_r[ci] <= vx;
              end
              tbpr_pkg::FUNC_TICK: begin
                if (set_age_r != 16'hffff) set_age_r <= set_age_r + 1'b1;
              end
              tbpr_pkg::FUNC_POINT: begin
                px_r <= vx;
                py_r <= vy;
                pz_r <= vz;
                last_r <= in_tlast;
                row_r <= '0;
                scan_r <= '0;
                hit_r <= 1'b0;
                state_r <= active ? S_ROW : S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_ROW: begin
          prod_r[0] <= coef_r[base] * px_r;
          prod_r[1] <= coef_r[base + 4'd1] * py_r;
          prod_r[2] <= coef_r[base + 4'd2] * pz_r;
          state_r <= S_SUM;
        end
        S_SUM: begin
          q_r[row_r] <= sum;
          if (row_r == 2'd2) begin
            state_r <= S_SCAN;
            scan_r <= scan_r + 1'b1;
          end else begin
            row_r <= row_r + 1'b1;
            state_r <= S_ROW;
          end
        end
        S_SCAN: begin
          if (hit_now) hit_r <= 1'b1;
          if (hit_now || scan_r == box_count_r) begin
            state_r <= S_DONE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r <= {7'b0, pz_r, py_r, px_r, ~hit_r};
            out_last_r <= last_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/tbpr_checker.sv =====
module tbpr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tdata, out_tlast}))
    else $error("unknown result fields");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind transformed_box_point_rejector tbpr_checker u_tbpr_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
